// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

    // Field widths fixed by the interface.
    localparam int ACT_W   = 3;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 5;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_SEND_BACK  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SEND_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_OVERWRITE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RECEIVE    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK       = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd5;

    // Reset value of the queue length register.
    localparam logic [CNT_W-1:0] QLEN_RESET = 5'd16;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DATA_W-1:0] item_data;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  item_count;
        logic [CNT_W-1:0]  free_space;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/rmq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module rmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ring_message_queue_front_back_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake              Payload
// ---------  ---------  ---------------------  ------------------------------------
// in         input      i_in_valid / o_in_stall  i_in_item  (action, item_data)
// out        output     o_out_valid / i_out_stall o_out_item (ok, read_data, count, free)
// cfg        input      i_cfg_valid / o_cfg_ready i_cfg_data (queue_length)
//
// One item is accepted every cycle while o_in_stall is low; an accepted item waits in the
// input register and moves into the result register when the result stage advances, where
// it is offered until the receiver takes it.
// The slot RAM read is registered and lines up with the result register, so a read
// issued by one item always sees the write made by the item before it.
// Reset is synchronous and active low; it sets the length to sixteen, the write slot
// and the count to zero and the read slot to the last slot in use, and the slot store
// is left as it is (its contents are undefined until written).
// A stall on the output holds the result and backs up into the input stage.
module ring_message_queue_front_back_core #(
    parameter int SLOT_COUNT = 16,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input item channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire rmq_pkg::t_in_item    i_in_item,
    // Result item channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output rmq_pkg::t_out_item        o_out_item,
    // Configuration write channel (queue_length).
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [rmq_pkg::CNT_W-1:0] i_cfg_data
);

    localparam int AW        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RESET_LEN = (int'(rmq_pkg::QLEN_RESET) > SLOT_COUNT) ?
                               SLOT_COUNT : int'(rmq_pkg::QLEN_RESET);
    localparam logic [rmq_pkg::CNT_W-1:0] RESET_RD = rmq_pkg::CNT_W'(RESET_LEN - 1);

    // Step a pointer forward, wrapping to zero once it reaches the length.
    function automatic logic [rmq_pkg::CNT_W-1:0] step_fwd(
        input logic [rmq_pkg::CNT_W-1:0] p,
        input logic [rmq_pkg::CNT_W-1:0] len
    );
        logic [rmq_pkg::CNT_W:0] n;
        n = {1'b0, p} + 1'b1;
        return (n >= {1'b0, len}) ? '0 : n[rmq_pkg::CNT_W-1:0];
    endfunction

    // Step a pointer backward, wrapping from zero to the last slot in use.
    function automatic logic [rmq_pkg::CNT_W-1:0] step_back(
        input logic [rmq_pkg::CNT_W-1:0] p,
        input logic [rmq_pkg::CNT_W-1:0] len
    );
        return (p == '0) ? len - 1'b1 : p - 1'b1;
    endfunction

    // Configuration register.
    logic [rmq_pkg::CNT_W-1:0] r_queue_length;

    // Queue state.
    logic [rmq_pkg::CNT_W-1:0] r_write_slot, n_write_slot;
    logic [rmq_pkg::CNT_W-1:0] r_read_slot,  n_read_slot;
    logic [rmq_pkg::CNT_W-1:0] r_count,      n_count;

    // Input stage.
    logic                r_a_valid;
    rmq_pkg::t_in_item   r_a_item;

    // Result stage.
    logic                      r_b_valid;
    logic                      r_b_ok;
    logic                      r_b_read;
    logic [rmq_pkg::CNT_W-1:0] r_b_count;
    logic [rmq_pkg::CNT_W-1:0] r_b_free;

    // Stage logic.
    logic                      advance_b;
    logic                      a_fire;
    logic [rmq_pkg::CNT_W-1:0] len;
    logic                      full;
    logic                      empty;
    logic                      ok_c;
    logic                      rd_c;
    logic                      we_c;
    logic [rmq_pkg::CNT_W-1:0] wptr_c;
    logic [rmq_pkg::CNT_W-1:0] rptr_c;
    logic [rmq_pkg::CNT_W-1:0] free_c;
    logic [WORD_BITS-1:0]      ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_length <= rmq_pkg::QLEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_queue_length <= i_cfg_data;
        end
    end

    // The length in use: zero acts as one, anything above the store size as the size.
    always_comb begin
        if (r_queue_length == '0) begin
            len = rmq_pkg::CNT_W'(1);
        end else if (int'(r_queue_length) > SLOT_COUNT) begin
            len = rmq_pkg::CNT_W'(SLOT_COUNT);
        end else begin
            len = r_queue_length;
        end
    end

    // Handshake. The input register refills whenever it empties into the result stage.
    assign advance_b   = !r_b_valid || !i_out_stall;
    assign a_fire      = r_a_valid && advance_b;
    assign o_in_stall  = r_a_valid && !advance_b;
    assign o_out_valid = r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_a_item <= i_in_item;
        end
    end

    // Action decode and next state for the item in the input register.
    assign full  = (r_count >= len);
    assign empty = (r_count == '0);

    always_comb begin
        n_write_slot = r_write_slot;
        n_read_slot  = r_read_slot;
        n_count      = r_count;
        ok_c         = 1'b0;
        rd_c         = 1'b0;
        we_c         = 1'b0;
        wptr_c       = r_write_slot;
        rptr_c       = step_fwd(r_read_slot, len);
        case (r_a_item.action)
            rmq_pkg::ACT_SEND_BACK: begin
                if (!full) begin
                    we_c         = 1'b1;
                    wptr_c       = r_write_slot;
                    n_write_slot = step_fwd(r_write_slot, len);
                    n_count      = r_count + 1'b1;
                    ok_c         = 1'b1;
                end
            end
            rmq_pkg::ACT_SEND_FRONT: begin
                if (!full) begin
                    we_c        = 1'b1;
                    wptr_c      = r_read_slot;
                    n_read_slot = step_back(r_read_slot, len);
                    n_count     = r_count + 1'b1;
                    ok_c        = 1'b1;
                end
            end
            rmq_pkg::ACT_OVERWRITE: begin
                // Writes in front of the oldest item; a nonzero count stays put.
                we_c        = 1'b1;
                wptr_c      = r_read_slot;
                n_read_slot = step_back(r_read_slot, len);
                if (empty) begin
                    n_count = rmq_pkg::CNT_W'(1);
                end
                ok_c        = 1'b1;
            end
            rmq_pkg::ACT_RECEIVE, rmq_pkg::ACT_PEEK: begin
                if (!empty) begin
                    rd_c = 1'b1;
                    ok_c = 1'b1;
                    if (r_a_item.action == rmq_pkg::ACT_RECEIVE) begin
                        n_read_slot = rptr_c;
                        n_count     = r_count - 1'b1;
                    end
                end
            end
            rmq_pkg::ACT_CLEAR: begin
                n_write_slot = '0;
                n_read_slot  = len - 1'b1;
                n_count      = '0;
                ok_c         = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign free_c = (n_count >= len) ? '0 : len - n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;
            r_read_slot  <= RESET_RD;
            r_count      <= '0;
        end else if (a_fire) begin
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_count      <= n_count;
        end
    end

    // Slot store. Pointers never reach the store size, so they address it directly.
    rmq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (a_fire && we_c),
        .i_waddr (AW'(wptr_c)),
        .i_wdata (WORD_BITS'(r_a_item.item_data)),
        .i_re    (a_fire && rd_c),
        .i_raddr (AW'(rptr_c)),
        .o_rdata (ram_rdata)
    );

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (advance_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_ok    <= ok_c;
            r_b_read  <= rd_c;
            r_b_count <= n_count;
            r_b_free  <= free_c;
        end
    end

    // The RAM output register holds while stalled, since reads are issued only on advance.
    always_comb begin
        o_out_item.ok         = r_b_ok;
        o_out_item.read_data  = r_b_read ? rmq_pkg::DATA_W'(ram_rdata) : '0;
        o_out_item.item_count = r_b_count;
        o_out_item.free_space = r_b_free;
    end

    // The input side stalls only when an item is actually held in the input register.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid)
        else $error("input stalled with an empty input register");

    // A send that finds the queue full leaves the count unchanged.
    a_full_send_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && full && (r_a_item.action == rmq_pkg::ACT_SEND_BACK ||
                            r_a_item.action == rmq_pkg::ACT_SEND_FRONT))
        |=> $stable(r_count))
        else $error("count changed on a send to a full queue");

    // A failed action never returns data.
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.ok) |-> (o_out_item.read_data == '0))
        else $error("failed action returned data");

    // Count plus free space never goes past the store size.
    a_count_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.free_space != '0) |->
        (int'(o_out_item.item_count) + int'(o_out_item.free_space) <= SLOT_COUNT))
        else $error("count plus free space exceeds the store size");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the ring message queue. Items are planned in an initial block,
// which runs a cycle-free model of the queue to work out each item's result.
// The driver offers items from that plan, and the monitor checks every result
// against the oldest outstanding prediction.
module tb;

    localparam int SLOTS         = 16;
    localparam int SETTLE_CYCLES = 8;     // covers the two-stage pipeline with margin
    localparam int QUIET_LIMIT   = 3000;  // cycles without any handshake before giving up
    localparam int CHOKE_CYCLES  = 80;    // long receiver hold-off used to back up the block
    localparam int PHASE_ITEMS   = 117;

    // Action codes that the block does not define; they must answer ok = 0.
    localparam logic [rmq_pkg::ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [rmq_pkg::ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    rmq_pkg::t_in_item          in_item   = '0;
    logic                       out_stall = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [rmq_pkg::CNT_W-1:0]  cfg_data  = '0;
    logic                       in_stall;
    logic                       out_valid;
    rmq_pkg::t_out_item         out_item;
    logic                       cfg_ready;

    ring_message_queue_front_back_core #(
        .SLOT_COUNT (SLOTS),
        .WORD_BITS  (rmq_pkg::DATA_W)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Shadow copy of the queue. Only the planning code in the initial block
    // touches it, so it always reflects the items planned so far, in order.
    logic [rmq_pkg::DATA_W-1:0] mq_slots [SLOTS];
    logic [SLOTS-1:0]           slot_valid = '0;   // slots that have ever been written
    logic [3:0]                 mq_wr;
    logic [3:0]                 mq_rd;
    logic [rmq_pkg::CNT_W-1:0]  mq_cnt;
    logic [rmq_pkg::CNT_W-1:0]  mq_len;

    // Items waiting to be offered, each paired with the result it must produce.
    rmq_pkg::t_in_item  outbox_items[$];
    rmq_pkg::t_out_item outbox_results[$];
    // Results owed by the block for items it has already accepted.
    rmq_pkg::t_out_item due_results[$];
    rmq_pkg::t_out_item in_want = '0;

    bit in_fire      = 1'b0;
    bit no_gaps      = 1'b0;
    int send_gap     = 0;
    int stall_left   = 0;
    int choke_req    = 0;
    int choke_served = 0;
    int choke_cnt    = 0;
    int quiet_cycles = 0;
    int fail_count   = 0;

    // The effective length: a register value of zero behaves as one slot, and
    // anything beyond the store size behaves as the full store.
    function automatic logic [rmq_pkg::CNT_W-1:0] span();
        if (mq_len == '0) return 5'd1;
        if (mq_len > SLOTS) return 5'(SLOTS);
        return mq_len;
    endfunction

    // A pointer at or past the end of the active length wraps to slot zero.
    function automatic logic [3:0] ahead(input logic [3:0] p);
        logic [rmq_pkg::CNT_W-1:0] n;
        n = {1'b0, p} + 1'b1;
        return (n >= span()) ? 4'd0 : n[3:0];
    endfunction

    function automatic logic [3:0] behind(input logic [3:0] p);
        return (p == 4'd0) ? 4'(span() - 1'b1) : p - 1'b1;
    endfunction

    function automatic void rewind();
        mq_wr  = 4'd0;
        mq_rd  = 4'(span() - 1'b1);
        mq_cnt = '0;
    endfunction

    // Applies one item to the shadow queue and returns the result it gives.
    function automatic rmq_pkg::t_out_item queue_apply(input rmq_pkg::t_in_item it);
        rmq_pkg::t_out_item        r;
        logic [rmq_pkg::CNT_W-1:0] len;
        logic [3:0]                nxt;
        r   = '0;
        len = span();
        case (it.action)
            rmq_pkg::ACT_SEND_BACK: begin
                if (mq_cnt < len) begin
                    mq_slots[mq_wr]   = it.item_data;
                    slot_valid[mq_wr] = 1'b1;
                    mq_wr             = ahead(mq_wr);
                    mq_cnt            = mq_cnt + 1'b1;
                    r.ok              = 1'b1;
                end
            end
            rmq_pkg::ACT_SEND_FRONT: begin
                if (mq_cnt < len) begin
                    mq_slots[mq_rd]   = it.item_data;
                    slot_valid[mq_rd] = 1'b1;
                    mq_rd             = behind(mq_rd);
                    mq_cnt            = mq_cnt + 1'b1;
                    r.ok              = 1'b1;
                end
            end
            rmq_pkg::ACT_OVERWRITE: begin
                // Goes in at the front; a nonempty count is left alone.
                mq_slots[mq_rd]   = it.item_data;
                slot_valid[mq_rd] = 1'b1;
                mq_rd             = behind(mq_rd);
                if (mq_cnt == '0) mq_cnt = 5'd1;
                r.ok = 1'b1;
            end
            rmq_pkg::ACT_RECEIVE, rmq_pkg::ACT_PEEK: begin
                if (mq_cnt != '0) begin
                    nxt         = ahead(mq_rd);
                    r.read_data = mq_slots[nxt];
                    if (it.action == rmq_pkg::ACT_RECEIVE) begin
                        mq_rd  = nxt;
                        mq_cnt = mq_cnt - 1'b1;
                    end
                    r.ok = 1'b1;
                end
            end
            rmq_pkg::ACT_CLEAR: begin
                rewind();
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.item_count = mq_cnt;
        r.free_space = (mq_cnt >= len) ? '0 : len - mq_cnt;
        return r;
    endfunction

    // Plans one item. A read that would land on a slot never written has no
    // defined answer, so such a read is turned into an append instead.
    task automatic offer(input logic [rmq_pkg::ACT_W-1:0] act,
                         input logic [rmq_pkg::DATA_W-1:0] word);
        rmq_pkg::t_in_item it;
        if ((act == rmq_pkg::ACT_RECEIVE || act == rmq_pkg::ACT_PEEK) && mq_cnt != '0 &&
            !slot_valid[ahead(mq_rd)])
            act = rmq_pkg::ACT_SEND_BACK;
        it.action    = act;
        it.item_data = word;
        outbox_items.push_back(it);
        outbox_results.push_back(queue_apply(it));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic logic [rmq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Filling stretches favor the send actions, draining stretches the reads,
    // so the queue swings between empty and full with random content.
    function automatic logic [rmq_pkg::ACT_W-1:0] pick_action(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 1) return rmq_pkg::ACT_CLEAR;
        if (r < 3) return (r == 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
        if (filling) begin
            if (r < 42) return rmq_pkg::ACT_SEND_BACK;
            if (r < 64) return rmq_pkg::ACT_SEND_FRONT;
            if (r < 74) return rmq_pkg::ACT_OVERWRITE;
            if (r < 88) return rmq_pkg::ACT_RECEIVE;
            return rmq_pkg::ACT_PEEK;
        end
        if (r < 16) return rmq_pkg::ACT_SEND_BACK;
        if (r < 24) return rmq_pkg::ACT_SEND_FRONT;
        if (r < 29) return rmq_pkg::ACT_OVERWRITE;
        if (r < 82) return rmq_pkg::ACT_RECEIVE;
        return rmq_pkg::ACT_PEEK;
    endfunction

    function automatic string show(input rmq_pkg::t_out_item r);
        return $sformatf("ok=%0d data=%08h count=%0d free=%0d",
                         r.ok, r.read_data, r.item_count, r.free_space);
    endfunction

    task automatic flag(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Waits until every planned item has been taken and answered, then lets
    // the pipeline run empty before the register may be touched. The check is
    // made at the rising edge, where the sender's outputs have settled.
    task automatic settle();
        while (outbox_items.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(input logic [rmq_pkg::CNT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        mq_len = value;
    endtask

    // Sender. A new item goes out only once the current one has been taken,
    // so a stalled item holds its payload. Gaps are drawn after each item.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || in_fire) begin
            if (send_gap != 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (outbox_items.size() != 0) begin
                in_valid <= 1'b1;
                in_item  <= outbox_items.pop_front();
                in_want  <= outbox_results.pop_front();
                send_gap <= no_gaps ? 0 : pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver. A requested choke holds the output off for a fixed stretch
    // while the sender keeps offering, which backs the block up into its input.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (choke_served < choke_req) begin
            out_stall <= 1'b1;
            if (choke_cnt == CHOKE_CYCLES - 1) begin
                choke_cnt    <= 0;
                choke_served <= choke_served + 1;
            end else begin
                choke_cnt <= choke_cnt + 1;
            end
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            out_stall <= 1'b0;
            if (!no_gaps && $urandom_range(0, 3) == 0) stall_left <= pick_gap() + 1;
        end
    end

    // Monitor. Handshakes are judged on the values present just before the
    // rising edge. An accepted item queues its prediction before the output
    // side is looked at, so a result is never matched ahead of its item.
    always @(posedge clk) begin
        rmq_pkg::t_out_item want;
        if (!rst_n) begin
            in_fire = 1'b0;
        end else begin
            in_fire = in_valid && !in_stall;
            if (in_fire) due_results.push_back(in_want);
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    flag($sformatf("result with nothing outstanding: %s", show(out_item)));
                end else begin
                    want = due_results.pop_front();
                    if (out_item.ok !== want.ok || out_item.read_data !== want.read_data ||
                        out_item.item_count !== want.item_count ||
                        out_item.free_space !== want.free_space)
                        flag($sformatf("expected %s, got %s", show(want), show(out_item)));
                end
            end
            if (in_fire || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        logic [rmq_pkg::CNT_W-1:0] lens [12];
        int  mode_left;
        bit  filling;
        lens      = '{5'd3, 5'd16, 5'd31, 5'd2, 5'd7, 5'd1,
                      5'd12, 5'd0, 5'd5, 5'd16, 5'd9, 5'd4};
        mode_left = 0;
        filling   = 1'b0;
        mq_len    = rmq_pkg::QLEN_RESET;
        rewind();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Full length after reset: reads on an empty queue, the undefined
        // action codes, overwrite on an empty queue, both insert ends, and
        // draining until a receive fails again.
        offer(rmq_pkg::ACT_RECEIVE, 32'h0);
        offer(rmq_pkg::ACT_PEEK, 32'h0);
        offer(ACT_SPARE_LO, 32'hDEADBEEF);
        offer(ACT_SPARE_HI, 32'hFFFFFFFF);
        offer(rmq_pkg::ACT_OVERWRITE, 32'hFFFFFFFF);
        offer(rmq_pkg::ACT_PEEK, 32'h0);
        offer(rmq_pkg::ACT_SEND_BACK, 32'h0);
        offer(rmq_pkg::ACT_SEND_FRONT, 32'hFFFFFFFF);
        offer(rmq_pkg::ACT_SEND_BACK, 32'hA5A5A5A5);
        repeat (5) offer(rmq_pkg::ACT_RECEIVE, 32'h0);
        offer(rmq_pkg::ACT_CLEAR, 32'h0);
        settle();

        // Single slot: sends on a full queue fail, overwrite on a full queue
        // replaces the word, and the pointers wrap onto themselves.
        write_length(5'd1);
        offer(rmq_pkg::ACT_CLEAR, 32'h0);
        offer(rmq_pkg::ACT_SEND_BACK, 32'h12345678);
        offer(rmq_pkg::ACT_SEND_BACK, 32'h87654321);
        offer(rmq_pkg::ACT_SEND_FRONT, 32'h87654321);
        offer(rmq_pkg::ACT_OVERWRITE, 32'h00000000);
        offer(rmq_pkg::ACT_PEEK, 32'h0);
        offer(rmq_pkg::ACT_RECEIVE, 32'h0);
        offer(rmq_pkg::ACT_SEND_FRONT, 32'h55AA55AA);
        offer(rmq_pkg::ACT_RECEIVE, 32'h0);
        settle();

        // A length of zero behaves as one slot.
        write_length(5'd0);
        offer(rmq_pkg::ACT_CLEAR, 32'h0);
        offer(rmq_pkg::ACT_OVERWRITE, 32'hC0FFEE11);
        offer(rmq_pkg::ACT_RECEIVE, 32'h0);

        // Random phases over a range of lengths. Every third phase keeps the
        // old pointers and count across the length change instead of clearing.
        for (int p = 0; p < 12; p++) begin
            settle();
            write_length(lens[p]);
            no_gaps = (p % 4 == 3);
            if (p % 3 != 2) offer(rmq_pkg::ACT_CLEAR, pick_word());
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (mode_left == 0) begin
                    filling   = !filling;
                    mode_left = $urandom_range(2, 2 * span() + 2);
                end
                mode_left--;
                offer(pick_action(filling), pick_word());
            end
            if (p == 1 || p == 6) choke_req++;
        end
        settle();

        while (due_results.size() != 0) begin
            flag($sformatf("no result for %s", show(due_results.pop_front())));
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rmq_pkg.sv
rtl/rmq_ram.sv
rtl/ring_message_queue_front_back_core.sv
verif/tb.sv
